@@ design/frra_pkg.sv @@
// shared types and constants for the frame rate meter
`default_nettype none

package frra_pkg;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 50;
  localparam int unsigned TPS_W       = 50;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned DIV_W       = 64;
  localparam int unsigned DIV_CNT_W   = 6;
  localparam int unsigned WHOLE_W     = 29;

  localparam logic [CFG_IDX_W-1:0] REG_TPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID = 2'd2;

  localparam logic [TPS_W-1:0]   TPS_RESET = 50'd1000000000000000;
  localparam logic [LIMIT_W-1:0] LOW_RESET = 16'd20;
  localparam logic [LIMIT_W-1:0] MID_RESET = 16'd40;

  // ceil(2^35 / 10), exact quotient by ten for any 32-bit value
  localparam logic [RATE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;

  localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_UPD   = 10'b00_0000_0010,
    S_SUB   = 10'b00_0000_0100,
    S_CHK   = 10'b00_0000_1000,
    S_DIVA  = 10'b00_0001_0000,
    S_LOADB = 10'b00_0010_0000,
    S_DIVB  = 10'b00_0100_0000,
    S_RATE  = 10'b00_1000_0000,
    S_SCALE = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic accept;
    logic upd;
    logic sub;
    logic rate_zero;
    logic div_load_a;
    logic div_load_b;
    logic div_step;
    logic rate_div;
    logic whole_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/frame_rate_rolling_average_core.sv @@
// top level of the rolling average frame rate meter
`default_nettype none

// Takes one frame timestamp per word and returns one word with the average
// frame rate in tenths over the last WINDOW intervals, its class and a known
// flag. A word that forms a rate goes through two 64-step passes of the
// shared one-bit-per-cycle divider (sum by sample count, then ten times
// ticks per second by the average) before the next word is accepted; a word
// with no previous timestamp, a zero sum or an average below one tick skips
// the divider. The ring needs no clearing pass after reset.
// Configuration writes are expected only while the block is idle.
module frame_rate_rolling_average_core
  import frra_pkg::*;
#(
  parameter int unsigned WINDOW = 60
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // frame_time
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // rate_tenths, rate_class, zero pad
  output logic                        m_axis_tuser,   // rate_known
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t               cmd;
  status_t            status;
  logic [RATE_W-1:0]  rate_tenths;
  logic [CLASS_W-1:0] rate_class;
  logic               rate_known;

  frra_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  frra_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .frame_time_i  (s_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .rate_tenths_o (rate_tenths),
    .rate_class_o  (rate_class),
    .rate_known_o  (rate_known)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - RATE_W - CLASS_W)'(0), rate_class, rate_tenths};
  assign m_axis_tuser = rate_known;

endmodule

`default_nettype wire

@@ design/frra_ctrl.sv @@
// sequencing state machine for the frame rate meter
`default_nettype none

module frra_ctrl
  import frra_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (status_i.skip) begin
          cmd_o.rate_zero = 1'b1;
          state_d         = S_SCALE;
        end else begin
          cmd_o.div_load_a = 1'b1;
          state_d          = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_LOADB;
        end
      end
      S_LOADB: begin
        cmd_o.div_load_b = 1'b1;
        state_d          = S_DIVB;
      end
      S_DIVB: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_RATE;
        end
      end
      S_RATE: begin
        cmd_o.rate_div = 1'b1;
        state_d        = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.whole_calc = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/frra_dp.sv @@
// interval ring, running sum, shared divider and output register
`default_nettype none

module frra_dp
  import frra_pkg::*;
#(
  parameter int unsigned WINDOW = 60
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output status_t                     status_o,
  input  wire logic [IN_TDATA_W-1:0]  frame_time_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [RATE_W-1:0]           rate_tenths_o,
  output logic [CLASS_W-1:0]          rate_class_o,
  output logic                        rate_known_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  logic [TPS_W-1:0]   tps_q;
  logic [LIMIT_W-1:0] low_q, mid_q;

  logic [DIV_W-1:0]   ring_mem [WINDOW];
  logic [DIV_W-1:0]   rd_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   count_q;
  logic [DIV_W-1:0]   sum_q, prev_q, delta_q, old_q;
  logic               has_prev_q;
  logic               full;

  logic [DIV_W-1:0]     rem_q, quo_q, dvs_q;
  logic [DIV_CNT_W-1:0] bit_cnt_q;
  logic [DIV_W:0]       partial, diff;
  logic                 ge;
  logic [DIV_W-1:0]     tps_x10;

  logic [RATE_W-1:0]   rate_q;
  logic                known_q;
  logic [2*RATE_W-1:0] recip_prod;
  logic [WHOLE_W-1:0]  whole_q;
  logic [CLASS_W-1:0]  rate_class;
  logic                out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
      low_q <= LOW_RESET;
      mid_q <= MID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TPS: tps_q <= cfg_data_i[TPS_W-1:0];
        REG_LOW: low_q <= cfg_data_i[LIMIT_W-1:0];
        REG_MID: mid_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // slots below the fill count are the only ones ever written
  assign full = (count_q == CNT_W'(WINDOW));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= ring_mem[slot_q];
    end
    if (cmd_i.upd && has_prev_q) begin
      ring_mem[slot_q] <= delta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      prev_q     <= '0;
      has_prev_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        prev_q     <= frame_time_i;
        has_prev_q <= (prev_q != '0);
      end
      if (cmd_i.upd && has_prev_q) begin
        sum_q <= sum_q + delta_q;
        if (slot_q == SLOT_W'(WINDOW - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
        if (!full) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.sub) begin
        sum_q <= sum_q - old_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      delta_q <= frame_time_i - prev_q;
    end
    if (cmd_i.upd) begin
      old_q <= (has_prev_q && full) ? rd_q : '0;
    end
  end

  assign status_o.skip = !has_prev_q || (sum_q == '0) || (sum_q < DIV_W'(count_q));

  // restoring divider, one quotient bit per cycle
  assign partial = {rem_q, quo_q[DIV_W-1]};
  assign diff    = partial - {1'b0, dvs_q};
  assign ge      = !diff[DIV_W];
  assign tps_x10 = DIV_W'({tps_q, 3'b000}) + DIV_W'({tps_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load_a) begin
      rem_q     <= '0;
      quo_q     <= sum_q;
      dvs_q     <= DIV_W'(count_q);
      bit_cnt_q <= '0;
    end else if (cmd_i.div_load_b) begin
      rem_q     <= '0;
      quo_q     <= tps_x10;
      dvs_q     <= quo_q;
      bit_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
      quo_q     <= {quo_q[DIV_W-2:0], ge};
      bit_cnt_q <= bit_cnt_q + 1'b1;
    end
  end

  assign status_o.div_last = (bit_cnt_q == '1);

  // rate, whole rate and class
  assign recip_prod = rate_q * RECIP_TEN;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_zero) begin
      rate_q  <= '0;
      known_q <= 1'b0;
    end else if (cmd_i.rate_div) begin
      rate_q  <= (|quo_q[DIV_W-1:RATE_W]) ? '1 : quo_q[RATE_W-1:0];
      known_q <= 1'b1;
    end
    if (cmd_i.whole_calc) begin
      whole_q <= recip_prod[2*RATE_W-1:RECIP_SHIFT];
    end
  end

  always_comb begin
    if (whole_q < WHOLE_W'(low_q)) begin
      rate_class = CLASS_LOW;
    end else if (whole_q < WHOLE_W'(mid_q)) begin
      rate_class = CLASS_MID;
    end else begin
      rate_class = CLASS_HIGH;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rate_tenths_o <= rate_q;
      rate_class_o  <= rate_class;
      rate_known_o  <= known_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

endmodule

`default_nettype wire

@@ design/frra_checker.sv @@
// port level checks for the frame rate meter, bound to the top level
`default_nettype none

module frra_checker
  import frra_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // an unknown rate is reported as zero
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
    else $error("unknown rate not zero");

  // class code and padding
  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3 && m_axis_tdata[39:34] == 6'd0)
    else $error("bad class code or padding");

  // one word at a time: busy right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after acceptance");

endmodule

bind frame_rate_rolling_average_core frra_checker u_frra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
